/* hw/rtl/qtsd_pkg.sv */
package qtsd_pkg;

  localparam int NODES   = 6;
  localparam int NODE_W  = 3;
  localparam int COORD_W = 32;
  localparam int FRAC    = 16;
  localparam int NAT_W   = 18;
  localparam int SHAPE_W = 20;
  localparam int DERIV_W = 32;
  localparam int DET_W   = 48;
  localparam int DRV_W   = 24;   // natural derivatives and shape operands
  localparam int JAC_W   = 44;   // Jacobian entries, Q.16
  localparam int SPLIT   = 24;   // low part width when a Jacobian entry is split
  localparam int MA_W    = 45;
  localparam int MB_W    = 25;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 92;
  localparam int IN_W    = 104;
  localparam int OUT_W   = 136;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic signed [DRV_W-1:0] ONE = DRV_W'(1 << FRAC);

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic sub;
    logic shift;
  } mac_ctl_t;

  function automatic logic signed [DRV_W-1:0] nat_ds(input logic signed [NAT_W-1:0] s,
                                                     input logic signed [NAT_W-1:0] t,
                                                     input logic [NODE_W-1:0] k);
    logic signed [DRV_W-1:0] s4;
    logic signed [DRV_W-1:0] t4;
    logic signed [DRV_W-1:0] res;
    s4 = DRV_W'(s) <<< 2;
    t4 = DRV_W'(t) <<< 2;
    unique case (k)
      3'd0:    res = s4 - ONE;
      3'd2:    res = s4 + t4 - ONE - ONE - ONE;
      3'd3:    res = t4;
      3'd4:    res = -t4;
      3'd5:    res = (ONE <<< 2) - t4 - (s4 <<< 1);
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [DRV_W-1:0] nat_dt(input logic signed [NAT_W-1:0] s,
                                                     input logic signed [NAT_W-1:0] t,
                                                     input logic [NODE_W-1:0] k);
    logic signed [DRV_W-1:0] s4;
    logic signed [DRV_W-1:0] t4;
    logic signed [DRV_W-1:0] res;
    s4 = DRV_W'(s) <<< 2;
    t4 = DRV_W'(t) <<< 2;
    unique case (k)
      3'd1:    res = t4 - ONE;
      3'd2:    res = s4 + t4 - ONE - ONE - ONE;
      3'd3:    res = s4;
      3'd4:    res = (ONE <<< 2) - s4 - (t4 <<< 1);
      3'd5:    res = -s4;
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic signed [MA_W-1:0] shape_a(input logic signed [NAT_W-1:0] s,
                                                     input logic signed [NAT_W-1:0] t,
                                                     input logic [NODE_W-1:0] k);
    logic signed [DRV_W-1:0] sx;
    logic signed [DRV_W-1:0] tx;
    logic signed [DRV_W-1:0] res;
    sx = DRV_W'(s);
    tx = DRV_W'(t);
    unique case (k)
      3'd0:    res = sx;
      3'd1:    res = tx;
      3'd2:    res = ONE - sx - tx;
      3'd3:    res = sx <<< 2;
      3'd4:    res = tx <<< 2;
      3'd5:    res = sx <<< 2;
      default: res = '0;
    endcase
    return MA_W'(res);
  endfunction

  function automatic logic signed [MB_W-1:0] shape_b(input logic signed [NAT_W-1:0] s,
                                                     input logic signed [NAT_W-1:0] t,
                                                     input logic [NODE_W-1:0] k);
    logic signed [DRV_W-1:0] sx;
    logic signed [DRV_W-1:0] tx;
    logic signed [DRV_W-1:0] r;
    logic signed [DRV_W-1:0] res;
    sx = DRV_W'(s);
    tx = DRV_W'(t);
    r  = ONE - sx - tx;
    unique case (k)
      3'd0:    res = (sx <<< 1) - ONE;
      3'd1:    res = (tx <<< 1) - ONE;
      3'd2:    res = r - sx - tx;
      3'd3:    res = tx;
      3'd4:    res = r;
      3'd5:    res = r;
      default: res = '0;
    endcase
    return MB_W'(res);
  endfunction

  function automatic logic signed [SHAPE_W-1:0] sat_shape(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] v;
    logic signed [SHAPE_W-1:0] res;
    v = p >>> FRAC;
    if (&v[PROD_W-1:SHAPE_W-1] || ~|v[PROD_W-1:SHAPE_W-1]) res = v[SHAPE_W-1:0];
    else if (v[PROD_W-1]) res = {1'b1, {(SHAPE_W-1){1'b0}}};
    else res = {1'b0, {(SHAPE_W-1){1'b1}}};
    return res;
  endfunction

  function automatic logic signed [DET_W-1:0] sat_det(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] v;
    logic signed [DET_W-1:0] res;
    v = a >>> FRAC;
    if (&v[ACC_W-1:DET_W-1] || ~|v[ACC_W-1:DET_W-1]) res = v[DET_W-1:0];
    else if (v[ACC_W-1]) res = {1'b1, {(DET_W-1){1'b0}}};
    else res = {1'b0, {(DET_W-1){1'b1}}};
    return res;
  endfunction

endpackage

/* hw/rtl/quadratic_triangle_shape_derivatives.sv */
// Six-node quadratic triangle evaluator. A load beat (tuser = 0) writes the x,y of one node
// (corners 0-2, edge nodes 3-5); node indexes above five are dropped. An evaluate
// beat (tuser = 1) starts a run that emits six beats, one per node, with the shape value,
// dN/dx, dN/dy, the Jacobian determinant, a singular flag in tuser and tlast on node five.
// All products go through one 45x25 multiply-accumulate unit under a small sequencer, and
// each of the twelve global derivatives through a 32-step restoring divider; s_axis_tready
// is low during an evaluation. The last result beat may still wait in the output register
// while the next input beat is taken. Every node must be loaded before it is evaluated.
module quadratic_triangle_shape_derivatives (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // node_index[2:0], coord_x[34:3], coord_y[66:35], natural_s[84:67], natural_t[102:85]
  input  logic [qtsd_pkg::IN_W-1:0]      s_axis_tdata,
  // action
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // node_number[2:0], shape_value[22:3], deriv_x[54:23], deriv_y[86:55],
  // jacobian_det[134:87]
  output logic [qtsd_pkg::OUT_W-1:0]     m_axis_tdata,
  // singular
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHAPE = 7'b0000010,
    S_JAC   = 7'b0000100,
    S_DET   = 7'b0001000,
    S_NUM   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  localparam logic [qtsd_pkg::NODE_W-1:0] LAST = qtsd_pkg::NODE_W'(qtsd_pkg::NODES - 1);

  state_t state;
  logic   ph;
  logic [qtsd_pkg::NODE_W-1:0] k;
  logic [1:0] e;
  logic   dsel;

  logic [qtsd_pkg::NODE_W-1:0]        in_node;
  logic signed [qtsd_pkg::COORD_W-1:0] in_x;
  logic signed [qtsd_pkg::COORD_W-1:0] in_y;
  logic signed [qtsd_pkg::NAT_W-1:0]   in_s;
  logic signed [qtsd_pkg::NAT_W-1:0]   in_t;

  logic signed [qtsd_pkg::COORD_W-1:0] x_store [qtsd_pkg::NODES];
  logic signed [qtsd_pkg::COORD_W-1:0] y_store [qtsd_pkg::NODES];
  logic signed [qtsd_pkg::NAT_W-1:0]   s_reg;
  logic signed [qtsd_pkg::NAT_W-1:0]   t_reg;
  logic signed [qtsd_pkg::SHAPE_W-1:0] shp [qtsd_pkg::NODES];
  logic signed [qtsd_pkg::JAC_W-1:0]   jac [4];
  logic signed [qtsd_pkg::ACC_W-1:0]   det;
  logic signed [qtsd_pkg::DET_W-1:0]   det_out;
  logic                                sing;
  logic [qtsd_pkg::DERIV_W-1:0]        dx;
  logic [qtsd_pkg::DERIV_W-1:0]        dy;

  logic signed [qtsd_pkg::DRV_W-1:0]   ds_k;
  logic signed [qtsd_pkg::DRV_W-1:0]   dt_k;
  logic signed [qtsd_pkg::JAC_W-1:0]   det_src;
  logic signed [qtsd_pkg::MA_W-1:0]    op_a;
  logic signed [qtsd_pkg::MB_W-1:0]    op_b;
  qtsd_pkg::mac_ctl_t                  ctl;
  logic signed [qtsd_pkg::PROD_W-1:0]  mac_prod;
  logic signed [qtsd_pkg::ACC_W-1:0]   mac_acc;
  logic signed [qtsd_pkg::ACC_W-1:0]   mac_sum;
  logic                                div_start;
  logic                                div_done;
  logic [qtsd_pkg::DERIV_W-1:0]        div_quo;
  logic                                in_beat;
  logic                                out_free;

  assign in_node = s_axis_tdata[2:0];
  assign in_x    = s_axis_tdata[34:3];
  assign in_y    = s_axis_tdata[66:35];
  assign in_s    = s_axis_tdata[84:67];
  assign in_t    = s_axis_tdata[102:85];

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign ds_k = qtsd_pkg::nat_ds(s_reg, t_reg, k);
  assign dt_k = qtsd_pkg::nat_dt(s_reg, t_reg, k);

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    ctl       = '0;
    div_start = 1'b0;
    det_src   = e[1] ? jac[2] : jac[3];
    unique case (state)
      S_SHAPE: begin
        op_a = qtsd_pkg::shape_a(s_reg, t_reg, k);
        op_b = qtsd_pkg::shape_b(s_reg, t_reg, k);
      end
      S_JAC: begin
        op_a       = e[1] ? qtsd_pkg::MA_W'(y_store[k]) : qtsd_pkg::MA_W'(x_store[k]);
        op_b       = e[0] ? qtsd_pkg::MB_W'(dt_k) : qtsd_pkg::MB_W'(ds_k);
        ctl.acc_en = ph;
        ctl.clear  = (k == '0);
      end
      S_DET: begin
        // det = j00*j11 - j01*j10, the right factor split into high and low parts
        op_a = e[1] ? qtsd_pkg::MA_W'(jac[1]) : qtsd_pkg::MA_W'(jac[0]);
        op_b = e[0] ? qtsd_pkg::MB_W'({1'b0, det_src[qtsd_pkg::SPLIT-1:0]})
                    : qtsd_pkg::MB_W'(signed'(det_src[qtsd_pkg::JAC_W-1:qtsd_pkg::SPLIT]));
        ctl.acc_en = ph;
        ctl.clear  = (e == 2'd0);
        ctl.sub    = e[1];
        ctl.shift  = !e[0];
      end
      S_NUM: begin
        if (dsel) op_a = e[0] ? qtsd_pkg::MA_W'(jac[1]) : qtsd_pkg::MA_W'(jac[0]);
        else op_a = e[0] ? qtsd_pkg::MA_W'(jac[2]) : qtsd_pkg::MA_W'(jac[3]);
        op_b       = (dsel ^ e[0]) ? qtsd_pkg::MB_W'(dt_k) : qtsd_pkg::MB_W'(ds_k);
        ctl.acc_en = ph;
        ctl.clear  = !e[0];
        ctl.sub    = e[0];
      end
      S_DIV: div_start = !ph;
      default: ;
    endcase
  end

  qtsd_mac u_mac (
    .clk  (clk),
    .a    (op_a),
    .b    (op_b),
    .ctl  (ctl),
    .prod (mac_prod),
    .acc  (mac_acc),
    .sum  (mac_sum)
  );

  qtsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mac_acc),
    .den   (det),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ph            <= 1'b0;
      k             <= '0;
      e             <= '0;
      dsel          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          ph <= 1'b0;
          k  <= '0;
          e  <= '0;
          if (in_beat && s_axis_tuser == qtsd_pkg::ACT_EVAL) state <= S_SHAPE;
        end
        S_SHAPE: begin
          ph <= !ph;
          if (ph) begin
            if (k == LAST) begin
              k     <= '0;
              state <= S_JAC;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_JAC: begin
          ph <= !ph;
          if (ph) begin
            if (k == LAST) begin
              k <= '0;
              e <= e + 1'b1;
              if (e == 2'd3) state <= S_DET;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_DET: begin
          ph <= !ph;
          if (ph) begin
            e <= e + 1'b1;
            if (e == 2'd3) begin
              dsel  <= 1'b0;
              state <= (mac_sum == '0) ? S_OUT : S_NUM;
            end
          end
        end
        S_NUM: begin
          ph <= !ph;
          if (ph) begin
            e <= {1'b0, !e[0]};
            if (e[0]) state <= S_DIV;
          end
        end
        S_DIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (div_done) begin
            ph    <= 1'b0;
            dsel  <= !dsel;
            state <= dsel ? S_OUT : S_NUM;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (k == LAST) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= sing ? S_OUT : S_NUM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && s_axis_tuser == qtsd_pkg::ACT_LOAD &&
        in_node < qtsd_pkg::NODE_W'(qtsd_pkg::NODES)) begin
      x_store[in_node] <= in_x;
      y_store[in_node] <= in_y;
    end
    if (in_beat) begin
      s_reg <= in_s;
      t_reg <= in_t;
    end
    if (state == S_SHAPE && ph) shp[k] <= qtsd_pkg::sat_shape(mac_prod);
    if (state == S_JAC && ph && k == LAST) jac[e] <= mac_sum[qtsd_pkg::FRAC +: qtsd_pkg::JAC_W];
    if (state == S_DET && ph && e == 2'd3) begin
      det     <= mac_sum;
      det_out <= qtsd_pkg::sat_det(mac_sum);
      sing    <= (mac_sum == '0);
      dx      <= '0;
      dy      <= '0;
    end
    if (state == S_DIV && ph && div_done) begin
      if (dsel) dy <= div_quo;
      else dx <= div_quo;
    end
    if (state == S_OUT && out_free) begin
      m_axis_tdata <= {1'b0, det_out, dy, dx, shp[k], k};
      m_axis_tuser <= sing;
      m_axis_tlast <= (k == LAST);
    end
  end

endmodule

/* hw/rtl/qtsd_mac.sv */
module qtsd_mac (
  input  logic                                  clk,
  input  logic signed [qtsd_pkg::MA_W-1:0]      a,
  input  logic signed [qtsd_pkg::MB_W-1:0]      b,
  input  qtsd_pkg::mac_ctl_t                    ctl,
  output logic signed [qtsd_pkg::PROD_W-1:0]    prod,
  output logic signed [qtsd_pkg::ACC_W-1:0]     acc,
  output logic signed [qtsd_pkg::ACC_W-1:0]     sum
);

  logic signed [qtsd_pkg::ACC_W-1:0] term;
  logic signed [qtsd_pkg::ACC_W-1:0] base;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (ctl.acc_en) acc <= sum;
  end

  always_comb begin
    term = qtsd_pkg::ACC_W'(prod);
    if (ctl.shift) term = term <<< qtsd_pkg::SPLIT;
    base = ctl.clear ? '0 : acc;
    sum  = ctl.sub ? base - term : base + term;
  end

endmodule

/* hw/rtl/qtsd_div.sv */
module qtsd_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [qtsd_pkg::ACC_W-1:0]    num,
  input  logic signed [qtsd_pkg::ACC_W-1:0]    den,
  output logic                                 done,
  output logic [qtsd_pkg::DERIV_W-1:0]         quo
);

  localparam int SH_W  = qtsd_pkg::ACC_W + qtsd_pkg::FRAC;
  localparam int Q_W   = qtsd_pkg::DERIV_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [qtsd_pkg::ACC_W-1:0] nabs;
  logic [qtsd_pkg::ACC_W-1:0] dabs;
  logic [SH_W-1:0]            nsh;
  logic [qtsd_pkg::ACC_W-1:0] dreg;
  logic [qtsd_pkg::ACC_W-1:0] rem;
  logic [Q_W-1:0]             low;
  logic [Q_W-1:0]             q;
  logic                       ovf;
  logic                       neg;
  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [qtsd_pkg::ACC_W:0]   trial;
  logic                       fits;

  assign nabs  = num[qtsd_pkg::ACC_W-1] ? -num : num;
  assign dabs  = den[qtsd_pkg::ACC_W-1] ? -den : den;
  assign nsh   = {nabs, {qtsd_pkg::FRAC{1'b0}}};
  assign trial = {rem, low[Q_W-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= qtsd_pkg::ACC_W'(nsh[SH_W-1:Q_W]);
      low  <= nsh[Q_W-1:0];
      ovf  <= qtsd_pkg::ACC_W'(nsh[SH_W-1:Q_W]) >= dabs;
      neg  <= num[qtsd_pkg::ACC_W-1] ^ den[qtsd_pkg::ACC_W-1];
      dreg <= dabs;
      q    <= '0;
    end else if (busy) begin
      rem <= fits ? qtsd_pkg::ACC_W'(trial - {1'b0, dreg}) : trial[qtsd_pkg::ACC_W-1:0];
      q   <= {q[Q_W-2:0], fits};
      low <= low << 1;
    end
  end

  always_comb begin
    if (neg) begin
      if (ovf || (q > {1'b1, {(Q_W-1){1'b0}}})) quo = {1'b1, {(Q_W-1){1'b0}}};
      else quo = -q;
    end else begin
      if (ovf || q[Q_W-1]) quo = {1'b0, {(Q_W-1){1'b1}}};
      else quo = q;
    end
  end

endmodule

/* hw/rtl/qtsd_chk.sv */
module qtsd_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [qtsd_pkg::IN_W-1:0]      s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qtsd_pkg::OUT_W-1:0]     m_axis_tdata,
  input logic                           m_axis_tuser,
  input logic                           m_axis_tlast
);

  // tlast only on the final node
  a_last_node: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[2:0] == 3'(qtsd_pkg::NODES - 1))
    else $error("tlast on a node other than the last");

  // a singular Jacobian forces zero derivatives
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[86:23] == '0)
    else $error("nonzero derivative with singular flag");

  // an evaluate beat makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == qtsd_pkg::ACT_EVAL |=> !s_axis_tready)
    else $error("ready right after an evaluate beat");

  // no new input while an evaluation still has nodes to send
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready in the middle of an evaluation");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

endmodule

bind quadratic_triangle_shape_derivatives qtsd_chk u_qtsd_chk (.*);

/* sim/testbench.sv */
module testbench;

  localparam int LIMIT = 1500000;

  typedef struct {
    logic [qtsd_pkg::NODE_W-1:0]         node;
    logic signed [qtsd_pkg::SHAPE_W-1:0] shape;
    logic signed [qtsd_pkg::DERIV_W-1:0] dx;
    logic signed [qtsd_pkg::DERIV_W-1:0] dy;
    logic signed [qtsd_pkg::DET_W-1:0]   det;
    logic                                sing;
    logic                                last;
  } node_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [qtsd_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                       s_axis_tuser = qtsd_pkg::ACT_LOAD;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [qtsd_pkg::OUT_W-1:0] m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       m_axis_tlast;

  node_result_t     pending_nodes[$];
  logic signed [qtsd_pkg::COORD_W-1:0] elem_x[qtsd_pkg::NODES];
  logic signed [qtsd_pkg::COORD_W-1:0] elem_y[qtsd_pkg::NODES];
  int               errors = 0;
  int               cycles = 0;
  int               items = 0;
  bit               quiet = 1'b0;

  quadratic_triangle_shape_derivatives dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
  end

  function automatic logic signed [127:0] clamp(input logic signed [127:0] v, input int w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (w - 1)) - 1;
    lo = -(128'sd1 <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Build the six expected beats of one evaluation at s,t.
  function automatic void predict_evaluation(input logic signed [qtsd_pkg::NAT_W-1:0] sn,
                                             input logic signed [qtsd_pkg::NAT_W-1:0] tn);
    longint s, t, r, one;
    longint shp[qtsd_pkg::NODES];
    longint ds[qtsd_pkg::NODES];
    longint dt[qtsd_pkg::NODES];
    logic signed [127:0] a00, a01, a10, a11, det, num_x, num_y;
    node_result_t res;
    one = 64'sd1 << qtsd_pkg::FRAC;
    s = sn;
    t = tn;
    r = one - s - t;
    shp[0] = (s * (2 * s - one)) >>> qtsd_pkg::FRAC;
    shp[1] = (t * (2 * t - one)) >>> qtsd_pkg::FRAC;
    shp[2] = (r * (r - s - t)) >>> qtsd_pkg::FRAC;
    shp[3] = (4 * s * t) >>> qtsd_pkg::FRAC;
    shp[4] = (4 * t * r) >>> qtsd_pkg::FRAC;
    shp[5] = (4 * s * r) >>> qtsd_pkg::FRAC;
    ds[0] = 4 * s - one;              dt[0] = 0;
    ds[1] = 0;                        dt[1] = 4 * t - one;
    ds[2] = 4 * s + 4 * t - 3 * one;  dt[2] = ds[2];
    ds[3] = 4 * t;                    dt[3] = 4 * s;
    ds[4] = -4 * t;                   dt[4] = 4 * one - 4 * s - 8 * t;
    ds[5] = 4 * one - 4 * t - 8 * s;  dt[5] = -4 * s;
    a00 = 0; a01 = 0; a10 = 0; a11 = 0;
    for (int i = 0; i < qtsd_pkg::NODES; i++) begin
      a00 = a00 + 128'(elem_x[i]) * 128'(ds[i]);
      a01 = a01 + 128'(elem_x[i]) * 128'(dt[i]);
      a10 = a10 + 128'(elem_y[i]) * 128'(ds[i]);
      a11 = a11 + 128'(elem_y[i]) * 128'(dt[i]);
    end
    a00 = a00 >>> qtsd_pkg::FRAC;
    a01 = a01 >>> qtsd_pkg::FRAC;
    a10 = a10 >>> qtsd_pkg::FRAC;
    a11 = a11 >>> qtsd_pkg::FRAC;
    det = a00 * a11 - a01 * a10;
    for (int k = 0; k < qtsd_pkg::NODES; k++) begin
      res.node  = k[qtsd_pkg::NODE_W-1:0];
      res.shape = qtsd_pkg::SHAPE_W'(clamp(128'(shp[k]), qtsd_pkg::SHAPE_W));
      res.sing  = (det == 0);
      res.last  = (k == qtsd_pkg::NODES - 1);
      res.det   = qtsd_pkg::DET_W'(clamp(det >>> qtsd_pkg::FRAC, qtsd_pkg::DET_W));
      if (res.sing) begin
        res.dx = '0;
        res.dy = '0;
      end else begin
        num_x = 128'(ds[k]) * a11 - 128'(dt[k]) * a10;
        num_y = 128'(dt[k]) * a00 - 128'(ds[k]) * a01;
        res.dx = qtsd_pkg::DERIV_W'(clamp((num_x <<< qtsd_pkg::FRAC) / det,
                                          qtsd_pkg::DERIV_W));
        res.dy = qtsd_pkg::DERIV_W'(clamp((num_y <<< qtsd_pkg::FRAC) / det,
                                          qtsd_pkg::DERIV_W));
      end
      pending_nodes.push_back(res);
    end
  endfunction

  task automatic send_beat(input logic act, input logic [qtsd_pkg::NODE_W-1:0] idx,
                           input logic [qtsd_pkg::COORD_W-1:0] cx,
                           input logic [qtsd_pkg::COORD_W-1:0] cy,
                           input logic [qtsd_pkg::NAT_W-1:0] sn,
                           input logic [qtsd_pkg::NAT_W-1:0] tn);
    if (!quiet && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= qtsd_pkg::IN_W'({tn, sn, cy, cx, idx});
    do @(posedge clk); while (!s_axis_tready);
    items++;
    if (act == qtsd_pkg::ACT_EVAL) begin
      predict_evaluation(sn, tn);
    end else if (idx < qtsd_pkg::NODES) begin
      elem_x[idx] = cx;
      elem_y[idx] = cy;
    end
  endtask

  task automatic load_node(input int idx, input logic [qtsd_pkg::COORD_W-1:0] cx,
                           input logic [qtsd_pkg::COORD_W-1:0] cy);
    send_beat(qtsd_pkg::ACT_LOAD, idx[qtsd_pkg::NODE_W-1:0], cx, cy,
              qtsd_pkg::NAT_W'($urandom), qtsd_pkg::NAT_W'($urandom));
  endtask

  task automatic evaluate(input logic [qtsd_pkg::NAT_W-1:0] sn,
                          input logic [qtsd_pkg::NAT_W-1:0] tn);
    send_beat(qtsd_pkg::ACT_EVAL, qtsd_pkg::NODE_W'($urandom), $urandom, $urandom, sn, tn);
  endtask

  // Hold off the sender until every outstanding beat has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    node_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_nodes.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_nodes.pop_front();
        if (m_axis_tdata[2:0] !== want.node) begin
          $error("node_number expected %0d actual %0d", want.node, m_axis_tdata[2:0]);
          errors++;
        end
        if ($signed(m_axis_tdata[22:3]) !== want.shape) begin
          $error("shape_value expected %0d actual %0d", want.shape,
                 $signed(m_axis_tdata[22:3]));
          errors++;
        end
        if ($signed(m_axis_tdata[54:23]) !== want.dx) begin
          $error("deriv_x expected %0d actual %0d", want.dx, $signed(m_axis_tdata[54:23]));
          errors++;
        end
        if ($signed(m_axis_tdata[86:55]) !== want.dy) begin
          $error("deriv_y expected %0d actual %0d", want.dy, $signed(m_axis_tdata[86:55]));
          errors++;
        end
        if ($signed(m_axis_tdata[134:87]) !== want.det) begin
          $error("jacobian_det expected %0d actual %0d", want.det,
                 $signed(m_axis_tdata[134:87]));
          errors++;
        end
        if (m_axis_tuser !== want.sing) begin
          $error("singular expected %0b actual %0b", want.sing, m_axis_tuser);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_node expected %0b actual %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  task automatic load_reference_element();
    load_node(0, 32'sh0000_0000, 32'sh0000_0000);
    load_node(1, 32'sh0002_0000, 32'sh0000_0000);
    load_node(2, 32'sh0000_0000, 32'sh0002_0000);
    load_node(3, 32'sh0001_0000, 32'sh0000_0000);
    load_node(4, 32'sh0001_0000, 32'sh0001_0000);
    load_node(5, 32'sh0000_0000, 32'sh0001_0000);
  endtask

  task automatic test_natural_extremes();
    load_reference_element();
    evaluate(18'sd0, 18'sd0);
    evaluate(18'sh10000, 18'sd0);
    evaluate(18'sd0, 18'sh10000);
    evaluate(18'sh05555, 18'sh05555);
    evaluate(18'sh20000, 18'sh20000);
    evaluate(18'sh1FFFF, 18'sh1FFFF);
    evaluate(18'sh20000, 18'sh1FFFF);
  endtask

  task automatic test_ignored_index();
    load_node(6, 32'h7FFF_FFFF, 32'h8000_0000);
    load_node(7, 32'h1234_5678, 32'h8765_4321);
    evaluate(18'sh04000, 18'sh08000);
  endtask

  task automatic test_degenerate();
    for (int i = 0; i < qtsd_pkg::NODES; i++) load_node(i, 32'sh0003_0000, 32'shFFFF_0000);
    evaluate(18'sh04000, 18'sh04000);
    drain();
  endtask

  task automatic test_coord_extremes();
    load_node(0, 32'sh8000_0000, 32'sh8000_0000);
    load_node(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    load_node(2, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_node(3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    load_node(4, 32'sh0000_0001, 32'shFFFF_FFFF);
    load_node(5, 32'shFFFF_FFFF, 32'sh0000_0001);
    evaluate(18'sh1FFFF, 18'sh20000);
    evaluate(18'sh00001, 18'sh3FFFF);
  endtask

  function automatic logic [qtsd_pkg::COORD_W-1:0] pick_coord(input int base);
    if ($urandom_range(9) == 0) return $urandom;
    return qtsd_pkg::COORD_W'(base + $signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [qtsd_pkg::NAT_W-1:0] pick_natural();
    if ($urandom_range(3) == 0) return qtsd_pkg::NAT_W'($urandom);
    return qtsd_pkg::NAT_W'($urandom_range(65536));
  endfunction

  task automatic test_random(input int upto);
    int bx, by, sz;
    while (items < upto) begin
      if ($urandom_range(9) == 0) begin
        // stray loads: ignored indexes or a single node moved
        load_node($urandom_range(7), $urandom, $urandom);
      end else begin
        bx = $signed($urandom_range(200000)) - 100000;
        by = $signed($urandom_range(200000)) - 100000;
        sz = $urandom_range(200000, 1);
        load_node(0, pick_coord(bx), pick_coord(by));
        load_node(1, pick_coord(bx + sz), pick_coord(by));
        load_node(2, pick_coord(bx), pick_coord(by + sz));
        load_node(3, pick_coord(bx + sz / 2), pick_coord(by));
        load_node(4, pick_coord(bx + sz / 2), pick_coord(by + sz / 2));
        load_node(5, pick_coord(bx), pick_coord(by + sz / 2));
      end
      repeat ($urandom_range(3, 1)) evaluate(pick_natural(), pick_natural());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_natural_extremes();
    test_ignored_index();
    test_degenerate();
    test_coord_extremes();
    quiet = 1'b1;
    test_random(200);
    drain();
    quiet = 1'b0;
    test_random(320);
    drain();
    repeat (600) @(posedge clk);
    if (pending_nodes.size() != 0) begin
      $error("%0d result beats never arrived", pending_nodes.size());
      errors++;
    end
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/qtsd_pkg.sv
hw/rtl/qtsd_mac.sv
hw/rtl/qtsd_div.sv
hw/rtl/quadratic_triangle_shape_derivatives.sv
hw/rtl/qtsd_chk.sv
sim/testbench.sv
